FILE: rtl/ssrg_pkg.sv
`default_nettype none
package ssrg_pkg;

  localparam int unsigned LVL_W = 16;
  localparam int unsigned TS_W  = 32;
  localparam int unsigned DIV_W = 32;
  localparam int unsigned CNT_W = $clog2(DIV_W);
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;

  // input command codes
  typedef enum logic [1:0] {
    CMD_RECONF  = 2'd0,
    CMD_START   = 2'd1,
    CMD_PROCESS = 2'd2
  } cmd_t;

  // register indexes on the config port (word address)
  typedef enum logic [1:0] {
    REG_START_LEVEL = 2'd0,
    REG_END_LEVEL   = 2'd1,
    REG_DURATION    = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_PSUB,
    ST_PABS,
    ST_PCMP,
    ST_RESP
  } state_t;

endpackage
`default_nettype wire

FILE: rtl/ssrg_div.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module ssrg_div
  import ssrg_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DIV_W-1:0] dividend,
  input  wire logic [DIV_W-1:0] divisor,
  output logic                  done,
  output logic      [DIV_W-1:0] quotient
);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DIV_W-1:0] rem_r;
  logic [DIV_W-1:0] quo_r;
  logic [DIV_W-1:0] dvs_r;

  logic [DIV_W:0]   shifted;
  logic [DIV_W:0]   trial;
  logic             fits;

  assign shifted = {rem_r, quo_r[DIV_W-1]};
  assign trial   = shifted - {1'b0, dvs_r};
  assign fits    = ~trial[DIV_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIV_W - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? trial[DIV_W-1:0] : shifted[DIV_W-1:0];
      quo_r <= {quo_r[DIV_W-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

FILE: rtl/soft_start_ramp_generator_top.sv
`default_nettype none
// Soft-start ramp generator. Each item runs from ST_IDLE to ST_RESP:
// reconfigure via ST_PREP and ST_DIV (the bit-serial divider), flat or
// zero-length reconfigure via ST_PREP, process tick via ST_PSUB, ST_PABS and
// ST_PCMP, start and unused commands directly. One item at a time: in_ready is
// high only in ST_IDLE. rst_n is synchronous, active low; it clears control
// state, config registers and ramp state (step size resets to +1).
module soft_start_ramp_generator_top
  import ssrg_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  // input channel
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        in_command,
  input  wire logic [TS_W-1:0]   in_time_stamp,
  // result channel
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   out_setup_ok,
  output logic                   out_level_changed,
  output logic                   out_finished,
  output logic      [LVL_W-1:0]  out_level,
  // config port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready
);

  state_t state_r, state_nxt;

  // config registers
  logic [LVL_W-1:0] start_level_r;
  logic [LVL_W-1:0] end_level_r;
  logic [TS_W-1:0]  duration_r;

  // ramp state
  logic [LVL_W-1:0] level_r;
  logic [LVL_W-1:0] steps_r;
  logic [TS_W-1:0]  last_r;
  logic [LVL_W-1:0] step_r;     // only the low 16 bits of the step ever matter
  logic [TS_W-1:0]  gap_r;
  logic [LVL_W-1:0] sto_steps_r;
  logic [LVL_W-1:0] sto_start_r;

  // per-item working registers
  logic [LVL_W-1:0] diff_r;
  logic             neg_r;
  logic             big_r;
  logic [TS_W-1:0]  stamp_r;
  logic [TS_W-1:0]  dt_r;
  logic             ok_r;
  logic             chg_r;

  // result register
  logic             out_valid_r;
  logic             out_ok_r;
  logic             out_chg_r;
  logic             out_fin_r;
  logic [LVL_W-1:0] out_level_r;

  logic             in_xfer;
  logic             cfg_wr;
  logic [1:0]       cfg_idx;
  logic             out_free;
  logic             degen;
  logic             big;
  logic             div_start;
  logic             div_done;
  logic [DIV_W-1:0] div_quo;
  logic [DIV_W-1:0] div_dividend;
  logic [DIV_W-1:0] div_divisor;
  logic [LVL_W-1:0] mag;
  logic             step_due;

  assign in_xfer  = in_valid && in_ready;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign cfg_idx  = paddr[3:2];
  assign out_free = !out_valid_r || out_ready;
  assign pready   = 1'b1;

  // ---------------------------------------------------------------------------
  // Config registers. The user must write only while the block is idle; the block itself does not enforce it.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_level_r <= '0;
      end_level_r   <= '0;
      duration_r    <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx_t'(cfg_idx))
        REG_START_LEVEL: start_level_r <= pwdata[LVL_W-1:0];
        REG_END_LEVEL:   end_level_r   <= pwdata[LVL_W-1:0];
        REG_DURATION:    duration_r    <= pwdata[TS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(cfg_idx))
      REG_START_LEVEL: prdata = {{(DATA_W-LVL_W){1'b0}}, start_level_r};
      REG_END_LEVEL:   prdata = {{(DATA_W-LVL_W){1'b0}}, end_level_r};
      REG_DURATION:    prdata = duration_r;
      default:         prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Reconfigure: a zero level difference or zero duration is a degenerate ramp.
  // Otherwise one division sets either the step size (level difference larger
  // than the duration: one step per tick) or the tick gap (unit steps).
  // ---------------------------------------------------------------------------
  assign degen        = (diff_r == '0) || (duration_r == '0);
  assign big          = {{(TS_W-LVL_W){1'b0}}, diff_r} > duration_r;
  assign div_dividend = big ? {{(DIV_W-LVL_W){1'b0}}, diff_r} : duration_r;
  assign div_divisor  = big ? duration_r : {{(DIV_W-LVL_W){1'b0}}, diff_r};
  assign mag          = big_r ? div_quo[LVL_W-1:0] : LVL_W'(1);

  ssrg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  // process tick: step once |stamp - last| reaches the gap and steps remain
  assign step_due = (dt_r >= gap_r) && (steps_r != '0);

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    div_start = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_xfer) begin
          case (in_command)
            CMD_RECONF:  state_nxt = ST_PREP;
            CMD_PROCESS: state_nxt = ST_PSUB;
            default:     state_nxt = ST_RESP;
          endcase
        end
      end
      ST_PREP: begin
        if (degen) begin
          state_nxt = ST_RESP;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) state_nxt = ST_RESP;
      end
      ST_PSUB: state_nxt = ST_PABS;
      ST_PABS: state_nxt = ST_PCMP;
      ST_PCMP: state_nxt = ST_RESP;
      ST_RESP: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Ramp state and per-item datapath
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r     <= '0;
      steps_r     <= '0;
      last_r      <= '0;
      step_r      <= LVL_W'(1);
      gap_r       <= '0;
      sto_steps_r <= '0;
      sto_start_r <= '0;
      ok_r        <= 1'b0;
      chg_r       <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            ok_r  <= 1'b0;
            chg_r <= 1'b0;
            if (in_command == CMD_START) begin
              last_r  <= in_time_stamp;
              steps_r <= sto_steps_r;
              level_r <= sto_start_r;
            end
          end
        end
        ST_PREP: begin
          if (degen) begin
            sto_steps_r <= '0;
            sto_start_r <= start_level_r;
            steps_r     <= '0;
            level_r     <= end_level_r;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            ok_r        <= 1'b1;
            level_r     <= start_level_r;
            sto_start_r <= start_level_r;
            last_r      <= '0;
            gap_r       <= big_r ? TS_W'(1) : div_quo;
            steps_r     <= big_r ? duration_r[LVL_W-1:0] : diff_r;
            sto_steps_r <= big_r ? duration_r[LVL_W-1:0] : diff_r;
            step_r      <= neg_r ? (~mag + LVL_W'(1)) : mag;
          end
        end
        ST_PCMP: begin
          if (step_due) begin
            chg_r   <= 1'b1;
            last_r  <= stamp_r;
            steps_r <= steps_r - 1'b1;
            level_r <= level_r + step_r;
          end
        end
        default: ;
      endcase
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      stamp_r <= in_time_stamp;
      neg_r   <= end_level_r < start_level_r;
      diff_r  <= (end_level_r > start_level_r) ? (end_level_r - start_level_r)
                                               : (start_level_r - end_level_r);
    end
    if (state_r == ST_PREP) begin
      big_r <= big;
    end
    if (state_r == ST_PSUB) begin
      dt_r <= stamp_r - last_r;
    end else if (state_r == ST_PABS) begin
      dt_r <= dt_r[TS_W-1] ? (~dt_r + TS_W'(1)) : dt_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register: loaded from the updated state once the slot is free.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_RESP && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_RESP && out_free) begin
      out_ok_r    <= ok_r;
      out_chg_r   <= chg_r;
      out_fin_r   <= steps_r == '0;
      out_level_r <= level_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_setup_ok      = out_ok_r;
  assign out_level_changed = out_chg_r;
  assign out_finished      = out_fin_r;
  assign out_level         = out_level_r;

endmodule
`default_nettype wire

FILE: dv/tb_soft_start_ramp_generator_top.sv
`default_nettype none
// Soft-start ramp generator bench. One item in, one result out, in order.
// Expected results are predicted at each input transfer and matched at each
// result transfer. Config writes only happen with the pipe drained.
module tb_soft_start_ramp_generator_top;
  import ssrg_pkg::*;

  // command 3 has no meaning in the block; it must leave all state alone
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam int unsigned CYCLE_LIMIT  = 500_000;
  localparam int unsigned RAMP_ITEMS   = 1400;  // well-formed ramp sequences
  localparam int unsigned NOISE_ITEMS  = 150;   // free-running random traffic
  localparam int unsigned MAX_IDLE     = 12;
  localparam int unsigned SETTLE_TICKS = 60;    // outlasts the slowest item (reconfigure)
  localparam int unsigned MAX_PRINTED  = 100;

  // one result, packed so that a queue of them stays simple
  typedef struct packed {
    logic             setup_ok;
    logic             level_changed;
    logic             finished;
    logic [LVL_W-1:0] level;
  } ramp_result_t;

  logic clk;
  logic rst_n = 1'b0;

  // input channel
  logic             in_valid      = 1'b0;
  logic             in_ready;
  logic [1:0]       in_command    = '0;
  logic [TS_W-1:0]  in_time_stamp = '0;

  // result channel
  logic             out_valid;
  logic             out_ready     = 1'b0;
  logic             out_setup_ok;
  logic             out_level_changed;
  logic             out_finished;
  logic [LVL_W-1:0] out_level;

  // config port
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [ADDR_W-1:0] paddr   = '0;
  logic [DATA_W-1:0] pwdata  = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  soft_start_ramp_generator_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_command        (in_command),
    .in_time_stamp     (in_time_stamp),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_setup_ok      (out_setup_ok),
    .out_level_changed (out_level_changed),
    .out_finished      (out_finished),
    .out_level         (out_level),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  // ---------------------------------------------------------------------------
  // Ramp predictor state. Mirrors the block's registers; the step is one bit wider.
  // ---------------------------------------------------------------------------
  logic [LVL_W-1:0] cfg_start    = '0;
  logic [LVL_W-1:0] cfg_end      = '0;
  logic [31:0]      cfg_duration = '0;

  logic [LVL_W-1:0] m_level       = '0;
  logic [15:0]      m_steps_left  = '0;
  logic [TS_W-1:0]  m_last_time   = '0;
  logic [16:0]      m_step        = 17'd1;  // two's complement, resets to +1
  logic [31:0]      m_gap         = '0;
  logic [15:0]      m_saved_steps = '0;
  logic [LVL_W-1:0] m_saved_start = '0;

  ramp_result_t expected_results[$];

  int unsigned items_sent   = 0;
  int unsigned error_count  = 0;
  int unsigned sink_stall   = 0;
  bit          tx_quiet     = 1'b0;  // sender runs back to back while set
  bit          rx_quiet     = 1'b0;  // receiver never stalls while set

  // Advance the ramp by one accepted item and return what the block must say.
  function automatic ramp_result_t ramp_model_step(input logic [1:0] cmd,
                                                   input logic [TS_W-1:0] stamp);
    ramp_result_t r;
    logic [31:0]  diff;
    logic [31:0]  mag;
    logic [31:0]  neg;
    logic [31:0]  tick_dist;
    r = '0;
    case (cmd)
      CMD_RECONF: begin
        diff = (cfg_end > cfg_start) ? ({16'd0, cfg_end} - {16'd0, cfg_start})
                                     : ({16'd0, cfg_start} - {16'd0, cfg_end});
        m_saved_start = cfg_start;
        if (diff == 0 || cfg_duration == 0) begin
          // flat or zero-length ramp: jump to the end level, no steps
          m_saved_steps = '0;
          m_steps_left  = '0;
          m_level       = cfg_end;
        end else begin
          m_level     = cfg_start;
          m_last_time = '0;
          if (diff > cfg_duration) begin
            // coarse: one multi-unit step per tick
            m_gap        = 32'd1;
            mag          = diff / cfg_duration;
            m_steps_left = cfg_duration[15:0];
          end else begin
            // fine: unit steps spread over the duration
            m_gap        = cfg_duration / diff;
            mag          = 32'd1;
            m_steps_left = diff[15:0];
          end
          neg           = 32'd0 - mag;
          m_step        = (cfg_end < cfg_start) ? neg[16:0] : mag[16:0];
          m_saved_steps = m_steps_left;
          r.setup_ok    = 1'b1;
        end
      end
      CMD_START: begin
        m_last_time  = stamp;
        m_steps_left = m_saved_steps;
        m_level      = m_saved_start;
      end
      CMD_PROCESS: begin
        // absolute wrapped distance; 0x8000_0000 stays 0x8000_0000
        tick_dist = stamp - m_last_time;
        if (tick_dist[31]) tick_dist = 32'd0 - tick_dist;
        if (tick_dist >= m_gap && m_steps_left != 0) begin
          m_last_time     = stamp;
          m_steps_left    = m_steps_left - 16'd1;
          m_level         = m_level + m_step[15:0];
          r.level_changed = 1'b1;
        end
      end
      default: ;
    endcase
    r.finished = (m_steps_left == 0);
    r.level    = m_level;
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    if (error_count < MAX_PRINTED)
      $display("ERROR @%0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
    error_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Clock and watchdog
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side: checks every transfer against the oldest expectation, then
  // draws how long to hold out_ready low before the next one.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_sink
    ramp_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        flag_mismatch("result transfer with nothing expected, level",
                      32'(out_level), 'x);
      end else begin
        want = expected_results.pop_front();
        if (out_setup_ok !== want.setup_ok)
          flag_mismatch("setup_ok", 32'(out_setup_ok), 32'(want.setup_ok));
        if (out_level_changed !== want.level_changed)
          flag_mismatch("level_changed", 32'(out_level_changed),
                        32'(want.level_changed));
        if (out_finished !== want.finished)
          flag_mismatch("finished", 32'(out_finished), 32'(want.finished));
        if (out_level !== want.level)
          flag_mismatch("level", 32'(out_level), 32'(want.level));
      end
      if ($urandom_range(0, 39) == 0) rx_quiet = !rx_quiet;
      sink_stall = rx_quiet ? 0 : $urandom_range(0, MAX_IDLE);
    end else if (!out_ready && sink_stall != 0) begin
      sink_stall--;
    end
    out_ready <= (sink_stall == 0);
  end

  // ---------------------------------------------------------------------------
  // Input side. in_valid is left high after a transfer so a back-to-back item
  // keeps it high without a drop; anything that is not a send lowers it first.
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic [1:0] cmd, input logic [TS_W-1:0] stamp);
    int unsigned idle;
    if ($urandom_range(0, 39) == 0) tx_quiet = !tx_quiet;
    idle = tx_quiet ? 0 : $urandom_range(0, MAX_IDLE);
    if (idle != 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_command    <= cmd;
    in_time_stamp <= stamp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_results.push_back(ramp_model_step(cmd, stamp));
    items_sent++;
  endtask

  // Hold off the sender until every expected result has been transferred.
  task automatic pause_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle; lands at the access edge.
  task automatic cfg_write(input reg_idx_t idx, input logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_START_LEVEL: cfg_start    = data[LVL_W-1:0];
      REG_END_LEVEL:   cfg_end      = data[LVL_W-1:0];
      REG_DURATION:    cfg_duration = data;
      default: ;
    endcase
  endtask

  // Drain, then load all three registers. Level registers sometimes carry
  // junk in the upper half, which the block must drop.
  task automatic program_ramp(input logic [LVL_W-1:0] lvl_from,
                              input logic [LVL_W-1:0] lvl_to,
                              input logic [31:0] dur);
    logic [15:0] junk_a;
    logic [15:0] junk_b;
    junk_a = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'd0;
    junk_b = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'd0;
    pause_for_results();
    cfg_write(REG_START_LEVEL, {junk_a, lvl_from});
    cfg_write(REG_END_LEVEL, {junk_b, lvl_to});
    cfg_write(REG_DURATION, dur);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Straight out of reset: no steps stored, level 0, unit step.
  task automatic test_reset_state();
    send_item(CMD_PROCESS, 32'h0000_0000);
    send_item(CMD_START, 32'hFFFF_FFFF);
    send_item(CMD_UNUSED, 32'hFFFF_FFFF);
  endtask

  // Equal levels, then zero duration: both refuse and jump to the end level.
  task automatic test_degenerate_setups();
    program_ramp(16'd1234, 16'd1234, 32'd100);
    send_item(CMD_RECONF, 32'd0);
    program_ramp(16'd1234, 16'd4000, 32'd0);
    send_item(CMD_RECONF, $urandom);
    send_item(CMD_START, 32'd7);
  endtask

  // Full level swing: a single 0xFFFF step up, then a slow unit ramp down
  // over the longest duration (gap 65537).
  task automatic test_full_swing();
    program_ramp(16'h0000, 16'hFFFF, 32'd1);
    send_item(CMD_RECONF, 32'd0);
    send_item(CMD_START, 32'd5);
    send_item(CMD_PROCESS, 32'd6);
    program_ramp(16'hFFFF, 16'h0000, 32'hFFFF_FFFF);
    send_item(CMD_RECONF, 32'd0);
    send_item(CMD_PROCESS, 32'd65536);
    send_item(CMD_PROCESS, 32'd65537);
  endtask

  // Gap of 0x8000_0000: only the most negative wrapped difference reaches it.
  task automatic test_half_range_gap();
    program_ramp(16'd0, 16'd1, 32'h8000_0000);
    send_item(CMD_RECONF, 32'd0);
    send_item(CMD_START, 32'h0000_0010);
    send_item(CMD_PROCESS, 32'h8000_000F);
    send_item(CMD_PROCESS, 32'h8000_0010);
  endtask

  // Downward ramp hit by a time stamp that runs backwards: distance is |d|.
  task automatic test_reverse_time();
    program_ramp(16'd100, 16'd90, 32'd50);
    send_item(CMD_RECONF, 32'd0);
    send_item(CMD_START, 32'd1000);
    send_item(CMD_PROCESS, 32'd995);
    send_item(CMD_PROCESS, 32'd999);
    send_item(CMD_UNUSED, 32'd0);
  endtask

  // Well-formed ramps with random shape: program, reconfigure, start, then
  // ticks aimed around the step gap, with stray commands mixed in.
  task automatic test_random_ramps();
    int unsigned      first;
    int unsigned      kind;
    int unsigned      diff;
    int unsigned      ticks;
    bit               up;
    logic [LVL_W-1:0] lvl_a;
    logic [LVL_W-1:0] lvl_b;
    logic [31:0]      dur;
    logic [TS_W-1:0]  stamp;
    first = items_sent;
    while (items_sent - first < RAMP_ITEMS) begin
      kind = $urandom_range(0, 9);
      up   = 1'($urandom_range(0, 1));
      if (kind == 0) begin
        // flat or zero-length
        lvl_a = 16'($urandom);
        lvl_b = $urandom_range(0, 1) ? lvl_a : 16'($urandom);
        dur   = (lvl_a == lvl_b) ? $urandom : 32'd0;
      end else if (kind == 9) begin
        // rails to rails
        lvl_a = up ? 16'h0000 : 16'hFFFF;
        lvl_b = ~lvl_a;
        case ($urandom_range(0, 3))
          0:       dur = 32'd1;
          1:       dur = 32'd65535;
          2:       dur = 32'hFFFF_FFFF;
          default: dur = $urandom;
        endcase
      end else begin
        if (kind <= 4) begin
          dur  = $urandom_range(1, 12);
          diff = $urandom_range(dur + 1, 65535);
        end else begin
          diff = $urandom_range(1, 12);
          dur  = $urandom_range(0, 3) != 0 ? diff * $urandom_range(1, 40) : $urandom;
          if (dur < diff) dur = diff;
        end
        if (up) begin
          lvl_a = 16'($urandom_range(0, 65535 - diff));
          lvl_b = lvl_a + diff[15:0];
        end else begin
          lvl_a = 16'($urandom_range(diff, 65535));
          lvl_b = lvl_a - diff[15:0];
        end
      end

      // now and then keep the old settings and just drain
      if ($urandom_range(0, 7) != 0)
        program_ramp(lvl_a, lvl_b, dur);
      else
        pause_for_results();

      send_item(CMD_RECONF, $urandom);
      if ($urandom_range(0, 5) != 0) send_item(CMD_START, $urandom);

      ticks = (m_steps_left > 30 ? 30 : m_steps_left) + $urandom_range(0, 3);
      repeat (ticks) begin
        if ($urandom_range(0, 11) == 0) begin
          // stray command: any code, so also restart, reconfigure mid-ramp, or unused code
          send_item(2'($urandom_range(0, 3)), $urandom);
        end else begin
          case ($urandom_range(0, 9))
            0:       stamp = m_last_time - m_gap;       // backwards by a gap
            1:       stamp = m_last_time + m_gap - 1;   // just short
            2:       stamp = $urandom;
            default: stamp = m_last_time + m_gap + $urandom_range(0, 3);
          endcase
          send_item(CMD_PROCESS, stamp);
        end
      end
    end
  endtask

  // Unshaped traffic: random commands and stamps, random register contents.
  task automatic test_random_noise();
    for (int unsigned i = 0; i < NOISE_ITEMS; i++) begin
      if (i % 50 == 0) program_ramp(16'($urandom), 16'($urandom), $urandom);
      send_item(2'($urandom_range(0, 3)), $urandom);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  initial begin : main
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_degenerate_setups();
    test_full_swing();
    test_half_range_gap();
    test_reverse_time();
    test_random_ramps();
    test_random_noise();

    // everything out, then give a late stray result time to show up
    pause_for_results();
    repeat (SETTLE_TICKS) @(posedge clk);

    if (error_count == 0 && expected_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
`default_nettype wire
